@@ rtl/core/altok_pkg.sv @@
// Shared types, codes and character helpers for the assembler line tokenizer.
`timescale 1ns / 1ps

package altok_pkg;

	// Result kinds
	localparam logic [2:0] KIND_NAME    = 3'd0;
	localparam logic [2:0] KIND_NUMBER  = 3'd1;
	localparam logic [2:0] KIND_STRING  = 3'd2;
	localparam logic [2:0] KIND_PUNCT   = 3'd3;
	localparam logic [2:0] KIND_BAD_NUM = 3'd4;
	localparam logic [2:0] KIND_UNTERM  = 3'd5;
	localparam logic [2:0] KIND_UNEXP   = 3'd6;
	localparam logic [2:0] KIND_DONE    = 3'd7;

	// Characters with a fixed role
	localparam logic [7:0] CH_SEMI   = 8'h3B;
	localparam logic [7:0] CH_SQUOTE = 8'h27;
	localparam logic [7:0] CH_DQUOTE = 8'h22;
	localparam logic [7:0] CH_UP_H   = 8'h48;
	localparam logic [7:0] CH_UP_B   = 8'h42;

	// Digit value that marks "no hex digit"
	localparam logic [4:0] DIGIT_NONE = 5'd16;

	// Lexer modes
	typedef enum logic [5:0] {
		MODE_IDLE     = 6'b000001,
		MODE_NAME     = 6'b000010,
		MODE_NUM      = 6'b000100,
		MODE_STR      = 6'b001000,
		MODE_SKIP_OK  = 6'b010000,
		MODE_SKIP_ERR = 6'b100000
	} mode_t;

	// Digit validity flags, one per base
	typedef struct packed {
		logic hex;
		logic dec;
		logic bin;
	} digit_ok_t;

	// One result word
	typedef struct packed {
		logic [2:0]  kind;
		logic [9:0]  start_col;
		logic [9:0]  text_len;
		logic [63:0] num_value;
		logic        wide;
		logic [7:0]  char_code;
		logic        last;
	} res_t;

	function automatic logic is_alpha(input logic [7:0] c);
		return (c inside {[8'h41:8'h5A], [8'h61:8'h7A]});
	endfunction

	function automatic logic is_digit(input logic [7:0] c);
		return (c inside {[8'h30:8'h39]});
	endfunction

	function automatic logic is_space(input logic [7:0] c);
		return (c inside {[8'd9:8'd13], 8'd32});
	endfunction

	// Letters and _ $ @ ?, shared by name start and name body
	function automatic logic is_name_char(input logic [7:0] c);
		return is_alpha(c) || (c inside {8'h5F, 8'h24, 8'h40, 8'h3F});
	endfunction

	function automatic logic is_mark_char(input logic [7:0] c);
		return (c inside {8'h2C, 8'h3A, 8'h5B, 8'h5D, 8'h28, 8'h29,
			8'h2B, 8'h2D, 8'h2A, 8'h2F});
	endfunction

	function automatic logic [7:0] to_upper(input logic [7:0] c);
		return (c inside {[8'h61:8'h7A]}) ? (c - 8'd32) : c;
	endfunction

	// Hex digit value 0..15, or DIGIT_NONE
	function automatic logic [4:0] digit_val(input logic [7:0] c);
		logic [7:0] u;
		u = to_upper(c);
		if (u inside {[8'h30:8'h39]}) begin
			return 5'(u - 8'h30);
		end else if (u inside {[8'h41:8'h46]}) begin
			return 5'(u - 8'h41 + 8'd10);
		end
		return DIGIT_NONE;
	endfunction

endpackage

@@ rtl/core/assembler_line_tokenizer_core.sv @@
// Top level of the assembler line tokenizer: lexer state, token logic and result queue.
`timescale 1ns / 1ps

// Assembler line tokenizer.
// Input channel (in_valid/in_ready): one word per source byte (ch), or an
// end-of-line mark (line_end = 1, ch ignored). Output channel
// (out_valid/out_ready): one word per token or error, with kind, start_col,
// text_len, num_value, wide, char_code and last.
// Each input word is decoded in the cycle it is accepted against the lexer
// state registers; its zero, one or two results enter a four-entry result
// queue, and the output word is driven from the queue registers. The block takes
// one byte per cycle while the queue has room for two results, so it
// sustains one word per cycle whenever each word yields at most one result;
// words that close a token and open another yield two and drain at the
// output rate of one result per cycle.
// Reset clears the lexer state to idle at column zero and empties the queue.
// When the receiver stalls, results wait in the queue and in_ready drops
// once fewer than two free entries remain; nothing is lost.
module assembler_line_tokenizer_core #(
	parameter int LINE_COLS = 1024
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        in_valid,
	output logic        in_ready,
	input  logic [7:0]  ch,
	input  logic        line_end,
	output logic        out_valid,
	input  logic        out_ready,
	output logic [2:0]  kind,
	output logic [9:0]  start_col,
	output logic [9:0]  text_len,
	output logic [63:0] num_value,
	output logic        wide,
	output logic [7:0]  char_code,
	output logic        last
);

	localparam int ColW = $clog2(LINE_COLS);
	localparam logic [ColW-1:0] LastCol = ColW'(LINE_COLS - 1);

	// Lexer state
	altok_pkg::mode_t     mode_q, mode_d;
	logic [ColW-1:0]      col_q, col_d;
	logic [ColW-1:0]      tok_start_q, tok_start_d;
	logic                 quote_dbl_q, quote_dbl_d;
	logic [63:0]          acc_bin_q, acc_bin_d;
	logic [63:0]          acc_dec_q, acc_dec_d;
	logic [63:0]          acc_hex_q, acc_hex_d;
	altok_pkg::digit_ok_t ok_q, ok_d;
	logic [7:0]           held_q, held_d;

	// Result queue
	altok_pkg::res_t      rq_q [4];
	logic [1:0]           wr_ptr_q, rd_ptr_q;
	logic [2:0]           cnt_q;

	logic                 in_acc, out_acc;
	logic [ColW-1:0]      col_inc;
	logic [ColW-1:0]      len_raw;
	logic [9:0]           len10;

	// Number close
	logic [7:0]           held_up;
	logic [4:0]           held_k;
	logic [63:0]          dec_final;
	logic [63:0]          fin_val;
	logic                 fin_ok;
	altok_pkg::res_t      fin_res;

	// Digit feed
	logic [4:0]           feed_k;
	logic [3:0]           feed_k4;

	// Fresh character decode
	altok_pkg::mode_t     sc_mode;
	logic                 sc_emit;
	altok_pkg::res_t      sc_res;
	logic                 sc_name, sc_num, sc_str;

	// Per-word results
	logic                 close_vld, sec_vld, do_start;
	altok_pkg::res_t      close_res, sec_res, res0, res1;
	logic [1:0]           n_res;
	logic [1:0]           push_n;

	altok_pkg::res_t      done_res;
	altok_pkg::res_t      head;

	assign in_acc  = in_valid && in_ready;
	assign out_acc = out_valid && out_ready;
	assign in_ready = (cnt_q <= 3'd2);

	assign col_inc = (col_q < LastCol) ? (col_q + ColW'(1)) : LastCol;
	assign len_raw = (col_q >= tok_start_q) ? (col_q - tok_start_q) : '0;
	assign len10   = 10'(len_raw);

	always_comb begin
		done_res      = '0;
		done_res.kind = altok_pkg::KIND_DONE;
		done_res.last = 1'b1;
	end

	// Settle the base of the open number from the held last character
	assign held_up   = altok_pkg::to_upper(held_q);
	assign held_k    = altok_pkg::digit_val(held_q);
	assign dec_final = (acc_dec_q << 3) + (acc_dec_q << 1) + 64'(held_k[3:0]);

	always_comb begin
		if (held_up == altok_pkg::CH_UP_H) begin
			fin_ok  = ok_q.hex;
			fin_val = acc_hex_q;
		end else if (held_up == altok_pkg::CH_UP_B) begin
			fin_ok  = ok_q.bin;
			fin_val = acc_bin_q;
		end else begin
			fin_ok  = ok_q.dec && (held_k < 5'd10);
			fin_val = dec_final;
		end
		fin_res           = '0;
		fin_res.start_col = 10'(tok_start_q);
		fin_res.text_len  = len10;
		if (fin_ok) begin
			fin_res.kind      = altok_pkg::KIND_NUMBER;
			fin_res.num_value = fin_val;
			fin_res.wide      = |fin_val[63:32];
		end else begin
			fin_res.kind = altok_pkg::KIND_BAD_NUM;
			fin_res.last = 1'b1;
		end
	end

	assign feed_k  = altok_pkg::digit_val(held_q);
	assign feed_k4 = feed_k[3:0];

	// Decode a character seen between tokens
	always_comb begin
		sc_mode = altok_pkg::MODE_IDLE;
		sc_emit = 1'b0;
		sc_res  = '0;
		sc_name = 1'b0;
		sc_num  = 1'b0;
		sc_str  = 1'b0;
		sc_res.start_col = 10'(col_q);
		sc_res.text_len  = 10'd1;
		sc_res.char_code = ch;
		if (ch == altok_pkg::CH_SEMI) begin
			sc_mode = altok_pkg::MODE_SKIP_OK;
		end else if (altok_pkg::is_space(ch)) begin
			sc_mode = altok_pkg::MODE_IDLE;
		end else if (altok_pkg::is_name_char(ch) || ch == 8'h2E) begin
			sc_mode = altok_pkg::MODE_NAME;
			sc_name = 1'b1;
		end else if (altok_pkg::is_digit(ch)) begin
			sc_mode = altok_pkg::MODE_NUM;
			sc_num  = 1'b1;
		end else if (ch == altok_pkg::CH_SQUOTE || ch == altok_pkg::CH_DQUOTE) begin
			sc_mode = altok_pkg::MODE_STR;
			sc_str  = 1'b1;
		end else if (altok_pkg::is_mark_char(ch)) begin
			sc_emit     = 1'b1;
			sc_res.kind = altok_pkg::KIND_PUNCT;
		end else begin
			sc_mode     = altok_pkg::MODE_SKIP_ERR;
			sc_emit     = 1'b1;
			sc_res.kind = altok_pkg::KIND_UNEXP;
			sc_res.last = 1'b1;
		end
	end

	// Next lexer state and the results of one word
	always_comb begin
		mode_d      = mode_q;
		col_d       = col_q;
		tok_start_d = tok_start_q;
		quote_dbl_d = quote_dbl_q;
		acc_bin_d   = acc_bin_q;
		acc_dec_d   = acc_dec_q;
		acc_hex_d   = acc_hex_q;
		ok_d        = ok_q;
		held_d      = held_q;
		close_vld   = 1'b0;
		close_res   = '0;
		sec_vld     = 1'b0;
		sec_res     = done_res;
		do_start    = 1'b0;

		if (line_end) begin
			// Flush the open token, then return to the reset state
			case (mode_q)
				altok_pkg::MODE_NAME: begin
					close_vld           = 1'b1;
					close_res.kind      = altok_pkg::KIND_NAME;
					close_res.start_col = 10'(tok_start_q);
					close_res.text_len  = len10;
					sec_vld             = 1'b1;
				end
				altok_pkg::MODE_NUM: begin
					close_vld = 1'b1;
					close_res = fin_res;
					sec_vld   = fin_ok;
				end
				altok_pkg::MODE_STR: begin
					close_vld           = 1'b1;
					close_res.kind      = altok_pkg::KIND_UNTERM;
					close_res.start_col = 10'(tok_start_q);
					close_res.text_len  = len10;
					close_res.last      = 1'b1;
				end
				altok_pkg::MODE_SKIP_ERR: begin
					sec_vld = 1'b0;
				end
				default: begin
					sec_vld = 1'b1;
				end
			endcase
			mode_d      = altok_pkg::MODE_IDLE;
			col_d       = '0;
			tok_start_d = '0;
			quote_dbl_d = 1'b0;
			acc_bin_d   = '0;
			acc_dec_d   = '0;
			acc_hex_d   = '0;
			ok_d        = '{hex: 1'b1, dec: 1'b1, bin: 1'b1};
			held_d      = '0;
		end else begin
			case (mode_q)
				altok_pkg::MODE_IDLE: begin
					do_start = 1'b1;
				end
				altok_pkg::MODE_NAME: begin
					if (!(altok_pkg::is_name_char(ch) || altok_pkg::is_digit(ch))) begin
						close_vld           = 1'b1;
						close_res.kind      = altok_pkg::KIND_NAME;
						close_res.start_col = 10'(tok_start_q);
						close_res.text_len  = len10;
						do_start            = 1'b1;
					end
				end
				altok_pkg::MODE_NUM: begin
					if (altok_pkg::is_alpha(ch) || altok_pkg::is_digit(ch)) begin
						// Feed the held character into all three bases, hold the new one
						ok_d.bin  = ok_q.bin && (feed_k < 5'd2);
						ok_d.dec  = ok_q.dec && (feed_k < 5'd10);
						ok_d.hex  = ok_q.hex && (feed_k < altok_pkg::DIGIT_NONE);
						acc_bin_d = {acc_bin_q[62:0], 1'b0} + 64'(feed_k4);
						acc_dec_d = (acc_dec_q << 3) + (acc_dec_q << 1) + 64'(feed_k4);
						acc_hex_d = {acc_hex_q[59:0], feed_k4};
						held_d    = ch;
					end else begin
						close_vld = 1'b1;
						close_res = fin_res;
						if (fin_ok) begin
							do_start = 1'b1;
						end else begin
							mode_d = altok_pkg::MODE_SKIP_ERR;
						end
					end
				end
				altok_pkg::MODE_STR: begin
					if (ch == (quote_dbl_q ? altok_pkg::CH_DQUOTE : altok_pkg::CH_SQUOTE)) begin
						close_vld           = 1'b1;
						close_res.kind      = altok_pkg::KIND_STRING;
						close_res.start_col = 10'(tok_start_q);
						close_res.text_len  = len10;
						mode_d              = altok_pkg::MODE_IDLE;
					end
				end
				default: begin
					mode_d = mode_q;
				end
			endcase

			// Handle the character as a fresh one
			if (do_start) begin
				mode_d  = sc_mode;
				sec_vld = sc_emit;
				sec_res = sc_res;
				if (sc_name || sc_num) begin
					tok_start_d = col_q;
				end
				if (sc_num) begin
					acc_bin_d = '0;
					acc_dec_d = '0;
					acc_hex_d = '0;
					ok_d      = '{hex: 1'b1, dec: 1'b1, bin: 1'b1};
					held_d    = ch;
				end
				if (sc_str) begin
					quote_dbl_d = (ch == altok_pkg::CH_DQUOTE);
					tok_start_d = col_inc;
				end
			end
			col_d = col_inc;
		end
	end

	// Pack results in order
	always_comb begin
		if (close_vld) begin
			res0  = close_res;
			res1  = sec_res;
			n_res = sec_vld ? 2'd2 : 2'd1;
		end else begin
			res0  = sec_res;
			res1  = sec_res;
			n_res = sec_vld ? 2'd1 : 2'd0;
		end
	end

	assign push_n = in_acc ? n_res : 2'd0;

	// Advance lexer state on each accepted word
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mode_q      <= altok_pkg::MODE_IDLE;
			col_q       <= '0;
			tok_start_q <= '0;
			quote_dbl_q <= 1'b0;
			acc_bin_q   <= '0;
			acc_dec_q   <= '0;
			acc_hex_q   <= '0;
			ok_q        <= '{hex: 1'b1, dec: 1'b1, bin: 1'b1};
			held_q      <= '0;
		end else if (in_acc) begin
			mode_q      <= mode_d;
			col_q       <= col_d;
			tok_start_q <= tok_start_d;
			quote_dbl_q <= quote_dbl_d;
			acc_bin_q   <= acc_bin_d;
			acc_dec_q   <= acc_dec_d;
			acc_hex_q   <= acc_hex_d;
			ok_q        <= ok_d;
			held_q      <= held_d;
		end
	end

	// Queue pointers and fill count
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			cnt_q    <= '0;
		end else begin
			wr_ptr_q <= wr_ptr_q + push_n;
			if (out_acc) begin
				rd_ptr_q <= rd_ptr_q + 2'd1;
			end
			cnt_q <= cnt_q + 3'(push_n) - 3'(out_acc);
		end
	end

	// Queue payload
	always_ff @(posedge clk) begin
		if (push_n != 2'd0) begin
			rq_q[wr_ptr_q] <= res0;
		end
		if (push_n == 2'd2) begin
			rq_q[wr_ptr_q + 2'd1] <= res1;
		end
	end

	// Drive the output word from the queue head
	assign head      = rq_q[rd_ptr_q];
	assign out_valid = (cnt_q != 3'd0);
	assign kind      = head.kind;
	assign start_col = head.start_col;
	assign text_len  = head.text_len;
	assign num_value = head.num_value;
	assign wide      = head.wide;
	assign char_code = head.char_code;
	assign last      = head.last;

`ifndef SYNTHESIS
	assert property (@(posedge clk) disable iff (!arst_n)
		cnt_q <= 3'd4)
		else $error("result queue overflow");

	assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && in_ready && line_end |=> col_q == '0 && mode_q == altok_pkg::MODE_IDLE)
		else $error("line end did not reset lexer");

	assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && kind != altok_pkg::KIND_NUMBER |-> num_value == 64'd0 && !wide)
		else $error("value on non-number result");

	assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && (kind == altok_pkg::KIND_DONE || kind == altok_pkg::KIND_BAD_NUM ||
		kind == altok_pkg::KIND_UNTERM || kind == altok_pkg::KIND_UNEXP) |-> last)
		else $error("final result without last");
`endif

endmodule
